[rtl/core/sdme_pkg.sv]
package sdme_pkg;

	typedef enum logic [2:0] {
		OPC_LOAD  = 3'd0,
		OPC_WRITE = 3'd1,
		OPC_READ  = 3'd2,
		OPC_COUNT = 3'd3,
		OPC_ISECT = 3'd4,
		OPC_DIST  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		K_LOAD  = 3'd0,
		K_WRITE = 3'd1,
		K_READ  = 3'd2,
		K_COUNT = 3'd3,
		K_ISECT = 3'd4,
		K_DIST  = 3'd5,
		K_NOP   = 3'd6
	} kind_t;

	typedef struct packed {
		kind_t        kind;
		logic [9:0]   idx;
		logic [63:0]  addr;
		logic [63:0]  addr2;
		logic [63:0]  data;
		logic [6:0]   qrad;
	} item_t;

	typedef struct packed {
		logic [6:0]  radius;
		logic [10:0] count;
	} cfg_t;

	typedef struct packed {
		logic  valid;
		item_t item;
	} queue_out_t;

	localparam logic CFG_RADIUS = 1'b0;
	localparam logic CFG_COUNT  = 1'b1;

	localparam logic [6:0]  RADIUS_RST = 7'd24;
	localparam logic [10:0] COUNT_RST  = 11'd1024;

	localparam logic [31:0] LFSR_SEED = 32'h0000_ACE1;
	localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;

	localparam logic signed [7:0] CNT_MAX = 8'sd127;
	localparam logic signed [7:0] CNT_MIN = -8'sd127;

endpackage

[rtl/core/sdme_front.sv]
module sdme_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [2:0]          opcode,
	input  logic [9:0]          location_index,
	input  logic [63:0]         address,
	input  logic [63:0]         second_address,
	input  logic [63:0]         data_word,
	input  logic [6:0]          query_radius,
	input  logic                clr_busy,
	input  logic                pop,
	output sdme_pkg::queue_out_t q_out
);
	import sdme_pkg::*;

	item_t      ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       push;
	logic       do_pop;
	item_t      new_item;

	// classify opcode
	always_comb begin
		new_item = '0;
		case (opcode)
			OPC_LOAD:  new_item.kind = K_LOAD;
			OPC_WRITE: new_item.kind = K_WRITE;
			OPC_READ:  new_item.kind = K_READ;
			OPC_COUNT: new_item.kind = K_COUNT;
			OPC_ISECT: new_item.kind = K_ISECT;
			OPC_DIST:  new_item.kind = K_DIST;
			default:   new_item.kind = K_NOP;
		endcase
		new_item.idx   = location_index;
		new_item.addr  = address;
		new_item.addr2 = second_address;
		new_item.data  = data_word;
		new_item.qrad  = query_radius;
	end

	assign in_stall = (cnt_q == 2'd2) || clr_busy;
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (cnt_q != 2'd0);

	assign q_out.valid = (cnt_q != 2'd0);
	assign q_out.item  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) ent_q[wr_ptr_q] <= new_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)   wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end

endmodule

[rtl/core/sdme_back.sv]
module sdme_back #(
	parameter int LOCATIONS = 1024,
	parameter int DIMENSION = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sdme_pkg::cfg_t       cfg,
	input  sdme_pkg::queue_out_t q_in,
	output logic                 pop,
	output logic                 clr_busy,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [10:0]          hit_count,
	output logic [63:0]          read_word,
	output logic [6:0]           location_distance
);
	import sdme_pkg::*;

	localparam int AW = (LOCATIONS > 1) ? $clog2(LOCATIONS) : 1;
	localparam int NW = $clog2(LOCATIONS + 1);
	localparam int RW = DIMENSION * 8;
	localparam logic [63:0] DIM_MASK =
		(DIMENSION == 64) ? {64{1'b1}} : ((64'd1 << DIMENSION) - 64'd1);

	typedef enum logic [5:0] {
		ST_CLEAR   = 6'b000001,
		ST_IDLE    = 6'b000010,
		ST_SCAN    = 6'b000100,
		ST_DRAIN   = 6'b001000,
		ST_RESOLVE = 6'b010000,
		ST_DONE    = 6'b100000
	} state_t;

	state_t state_q;

	logic [DIMENSION-1:0] addr_mem [LOCATIONS];
	logic [RW-1:0]        ctr_mem  [LOCATIONS];

	item_t       it_q;
	logic [NW-1:0] iss_q;
	logic [NW-1:0] lim_q;
	logic [NW-1:0] n_act;
	logic [AW-1:0] clr_idx_q;

	logic                 v_s1, v_s2;
	logic [AW-1:0]        idx_s1, idx_s2;
	logic [DIMENSION-1:0] loc_s1;
	logic [RW-1:0]        row_s1, row_s2;
	logic [6:0]           da_s2, db_s2;

	logic signed [17:0]   sums_q [DIMENSION];
	logic [DIMENSION-1:0] word_q;
	logic [31:0]          lfsr_q;
	logic [NW-1:0]        col_q;
	logic [10:0]          hits_q;
	logic [6:0]           dist_q;

	logic                 issue;
	logic [AW-1:0]        raddr;
	logic                 active_s2;
	logic [RW-1:0]        row_upd;
	logic                 ctr_we;
	logic [AW-1:0]        ctr_waddr;
	logic [RW-1:0]        ctr_wdata;
	logic                 idx_ok;
	logic                 tie;
	logic                 sbit;

	assign n_act = ({6'd0, cfg.count} > 17'(LOCATIONS)) ? NW'(LOCATIONS) : NW'(cfg.count);
	assign idx_ok = 32'(q_in.item.idx) < LOCATIONS;

	assign clr_busy = (state_q == ST_CLEAR);
	assign pop      = (state_q == ST_IDLE) && q_in.valid;
	assign issue    = (state_q == ST_SCAN) && (iss_q < lim_q);
	assign raddr    = (it_q.kind == K_DIST) ? AW'(it_q.idx) : iss_q[AW-1:0];

	// load path writes the address store
	always_ff @(posedge clk) begin
		if (pop && q_in.item.kind == K_LOAD && idx_ok)
			addr_mem[AW'(q_in.item.idx)] <= q_in.item.addr[DIMENSION-1:0];
		loc_s1 <= addr_mem[raddr];
	end

	// activation test at stage 2
	always_comb begin
		active_s2 = 1'b0;
		case (it_q.kind)
			K_WRITE, K_READ: active_s2 = (da_s2 <= cfg.radius);
			K_COUNT:         active_s2 = (da_s2 <= it_q.qrad);
			K_ISECT:         active_s2 = (da_s2 <= it_q.qrad) && (db_s2 <= it_q.qrad);
			default:         active_s2 = 1'b0;
		endcase
	end

	// saturating counter update, one lane per column
	always_comb begin
		logic signed [7:0] c;
		for (int j = 0; j < DIMENSION; j++) begin
			c = row_s2[j*8 +: 8];
			if (it_q.data[j]) row_upd[j*8 +: 8] = (c < CNT_MAX) ? c + 8'sd1 : c;
			else              row_upd[j*8 +: 8] = (c > CNT_MIN) ? c - 8'sd1 : c;
		end
	end

	assign ctr_we    = clr_busy || (v_s2 && active_s2 && it_q.kind == K_WRITE);
	assign ctr_waddr = clr_busy ? clr_idx_q : idx_s2;
	assign ctr_wdata = clr_busy ? '0 : row_upd;

	always_ff @(posedge clk) begin
		if (ctr_we) ctr_mem[ctr_waddr] <= ctr_wdata;
		row_s1 <= ctr_mem[raddr];
	end

	// pipeline payload
	always_ff @(posedge clk) begin
		idx_s1 <= raddr;
		idx_s2 <= idx_s1;
		row_s2 <= row_s1;
		da_s2  <= 7'($countones((64'(loc_s1) ^ it_q.addr) & DIM_MASK));
		db_s2  <= 7'($countones((64'(loc_s1) ^ it_q.addr2) & DIM_MASK));
	end

	assign tie  = (sums_q[0] == 18'sd0);
	assign sbit = tie ? lfsr_q[0] : (sums_q[0] > 18'sd0);

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int j = 0; j < DIMENSION; j++) sums_q[j] <= '0;
		end else if (v_s2 && active_s2 && it_q.kind == K_READ) begin
			for (int j = 0; j < DIMENSION; j++)
				sums_q[j] <= sums_q[j] + {{10{row_s2[j*8+7]}}, row_s2[j*8 +: 8]};
		end else if (state_q == ST_RESOLVE) begin
			for (int j = 0; j < DIMENSION - 1; j++) sums_q[j] <= sums_q[j+1];
			sums_q[DIMENSION-1] <= '0;
		end
		if (pop) word_q <= '0;
		else if (state_q == ST_RESOLVE)
			word_q <= (word_q >> 1) | (DIMENSION'(sbit) << (DIMENSION - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			iss_q     <= '0;
			lim_q     <= '0;
			col_q     <= '0;
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			lfsr_q    <= LFSR_SEED;
			hits_q    <= '0;
			dist_q    <= '0;
			out_valid <= 1'b0;
			it_q      <= '0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			if (out_valid && !out_stall) out_valid <= 1'b0;
			if (v_s2) begin
				if (active_s2) hits_q <= hits_q + 11'd1;
				if (it_q.kind == K_DIST) dist_q <= da_s2;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + AW'(1);
					if (32'(clr_idx_q) == LOCATIONS - 1) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_in.valid) begin
						it_q   <= q_in.item;
						hits_q <= '0;
						dist_q <= '0;
						iss_q  <= '0;
						col_q  <= '0;
						if (q_in.item.kind == K_DIST) lim_q <= NW'(idx_ok);
						else lim_q <= n_act;
						if (q_in.item.kind == K_LOAD || q_in.item.kind == K_NOP)
							state_q <= ST_DONE;
						else
							state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) iss_q <= iss_q + NW'(1);
					else state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2)
						state_q <= (it_q.kind == K_READ) ? ST_RESOLVE : ST_DONE;
				end
				ST_RESOLVE: begin
					if (tie) lfsr_q <= (lfsr_q >> 1) ^ (lfsr_q[0] ? LFSR_TAPS : 32'd0);
					col_q <= col_q + NW'(1);
					if (32'(col_q) == DIMENSION - 1) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && !out_valid) begin
			hit_count         <= hits_q;
			read_word         <= (it_q.kind == K_READ) ? 64'(word_q) : 64'd0;
			location_distance <= dist_q;
		end
	end

endmodule

[rtl/core/sparse_distributed_memory_engine_top.sv]
// Channel | Direction | Handshake          | Payload
// input   | in        | in_valid/in_stall   | opcode, location_index, address,
//         |           |                     | second_address, data_word, query_radius
// output  | out       | out_valid/out_stall | hit_count, read_word, location_distance
// config  | in        | cfg_we              | cfg_index, cfg_data
//
// Per item: load and unused opcodes skip the scan, distance reads only the indexed
// location, write/count/intersect/read scan the n locations in use, and read then
// resolves DIMENSION column sums; the counter memory scan takes one location per cycle.
// Reset: a clearing pass zeroes the counter memory, with in_stall high.
// A two-item queue takes new items while the back end works or out_stall holds a result.
module sparse_distributed_memory_engine_top #(
	parameter int LOCATIONS = 1024,
	parameter int DIMENSION = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [9:0]  location_index,
	input  logic [63:0] address,
	input  logic [63:0] second_address,
	input  logic [63:0] data_word,
	input  logic [6:0]  query_radius,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] hit_count,
	output logic [63:0] read_word,
	output logic [6:0]  location_distance,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data
);
	import sdme_pkg::*;

	cfg_t       cfg_q;
	queue_out_t q_out;
	logic       pop;
	logic       clr_busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.radius <= RADIUS_RST;
			cfg_q.count  <= COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RADIUS: cfg_q.radius <= cfg_data[6:0];
				CFG_COUNT:  cfg_q.count  <= cfg_data;
				default:    ;
			endcase
		end
	end

	// front: accept and classify, queue items
	sdme_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.opcode         (opcode),
		.location_index (location_index),
		.address        (address),
		.second_address (second_address),
		.data_word      (data_word),
		.query_radius   (query_radius),
		.clr_busy       (clr_busy),
		.pop            (pop),
		.q_out          (q_out)
	);

	// back: location scan, counter memory, read-sum resolve
	sdme_back #(
		.LOCATIONS (LOCATIONS),
		.DIMENSION (DIMENSION)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg               (cfg_q),
		.q_in              (q_out),
		.pop               (pop),
		.clr_busy          (clr_busy),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.hit_count         (hit_count),
		.read_word         (read_word),
		.location_distance (location_distance)
	);

endmodule

[rtl/core/sdme_checker.sv]
module sdme_checker #(
	parameter int LOCATIONS = 1024,
	parameter int DIMENSION = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [10:0] hit_count,
	input logic [63:0] read_word,
	input logic [6:0]  location_distance
);
	localparam logic [63:0] DIM_MASK =
		(DIMENSION == 64) ? {64{1'b1}} : ((64'd1 << DIMENSION) - 64'd1);

	a_reset_stall: assert property (@(posedge clk) !arst_n |=> in_stall)
		else $error("input not stalled in reset");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(read_word) && $stable(hit_count))
		else $error("stalled result changed");

	a_word_mask: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (read_word & ~DIM_MASK) == 64'd0)
		else $error("read word bits beyond dimension");

	a_hits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(hit_count) <= LOCATIONS)
		else $error("hit count beyond locations");

	a_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(location_distance) <= DIMENSION)
		else $error("distance beyond dimension");

endmodule

bind sparse_distributed_memory_engine_top sdme_checker #(
	.LOCATIONS (LOCATIONS),
	.DIMENSION (DIMENSION)
) u_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.in_stall          (in_stall),
	.out_valid         (out_valid),
	.out_stall         (out_stall),
	.hit_count         (hit_count),
	.read_word         (read_word),
	.location_distance (location_distance)
);

[tb/sdme_scoreboard.sv]
`timescale 1ns / 1ps

module sdme_scoreboard #(
	parameter int LOCATIONS = 1024,
	parameter int DIMENSION = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [2:0]  opcode,
	input  logic [9:0]  location_index,
	input  logic [63:0] address,
	input  logic [63:0] second_address,
	input  logic [63:0] data_word,
	input  logic [6:0]  query_radius,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [10:0] hit_count,
	input  logic [63:0] read_word,
	input  logic [6:0]  location_distance,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [10:0] cfg_data,
	output int          errors,
	output int          pending
);
	import sdme_pkg::*;

	typedef struct {
		logic [10:0] hits;
		logic [63:0] word;
		logic [6:0]  loc_dist;
	} result_t;

	localparam logic [63:0] DIM_MASK = (DIMENSION == 64) ? '1 : ((64'd1 << DIMENSION) - 1);

	logic [63:0]       loc_addr [LOCATIONS];
	logic signed [7:0] counter [LOCATIONS][DIMENSION];
	logic [31:0]       tie_lfsr;
	logic [6:0]        act_radius;
	logic [10:0]       loc_count;
	result_t           expected_q [$];

	function automatic int unsigned dist_of(logic [63:0] a, logic [63:0] b);
		return $countones((a ^ b) & DIM_MASK);
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// computes the result of one item and updates the shadow memory
	task automatic predict_item(output result_t r);
		int unsigned n;
		int          sums [DIMENSION];
		logic [63:0] a, a2;
		logic        t;
		r.hits = '0;
		r.word = '0;
		r.loc_dist = '0;
		a = address & DIM_MASK;
		a2 = second_address & DIM_MASK;
		n = (loc_count > LOCATIONS) ? LOCATIONS : loc_count;
		case (opcode)
			OPC_LOAD: begin
				if (location_index < LOCATIONS)
					loc_addr[location_index] = a;
			end
			OPC_WRITE: begin
				for (int i = 0; i < n; i++) begin
					if (dist_of(loc_addr[i], a) <= act_radius) begin
						r.hits++;
						for (int j = 0; j < DIMENSION; j++) begin
							if (data_word[j]) begin
								if (counter[i][j] < CNT_MAX)
									counter[i][j]++;
							end else begin
								if (counter[i][j] > CNT_MIN)
									counter[i][j]--;
							end
						end
					end
				end
			end
			OPC_READ: begin
				foreach (sums[j])
					sums[j] = 0;
				for (int i = 0; i < n; i++) begin
					if (dist_of(loc_addr[i], a) <= act_radius) begin
						r.hits++;
						for (int j = 0; j < DIMENSION; j++)
							sums[j] += counter[i][j];
					end
				end
				// zero sums take LFSR bits, lowest column first
				for (int j = 0; j < DIMENSION; j++) begin
					if (sums[j] > 0) begin
						r.word[j] = 1'b1;
					end else if (sums[j] == 0) begin
						t = tie_lfsr[0];
						tie_lfsr = tie_lfsr >> 1;
						if (t)
							tie_lfsr ^= LFSR_TAPS;
						r.word[j] = t;
					end
				end
			end
			OPC_COUNT: begin
				for (int i = 0; i < n; i++)
					if (dist_of(loc_addr[i], a) <= query_radius)
						r.hits++;
			end
			OPC_ISECT: begin
				for (int i = 0; i < n; i++)
					if (dist_of(loc_addr[i], a) <= query_radius &&
							dist_of(loc_addr[i], a2) <= query_radius)
						r.hits++;
			end
			OPC_DIST: begin
				if (location_index < LOCATIONS)
					r.loc_dist = 7'(dist_of(loc_addr[location_index], a));
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t r, e;
		if (!arst_n) begin
			foreach (counter[i, j])
				counter[i][j] = '0;
			foreach (loc_addr[i])
				loc_addr[i] = '0;
			tie_lfsr = LFSR_SEED;
			act_radius = RADIUS_RST;
			loc_count = COUNT_RST;
			expected_q.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_RADIUS)
					act_radius = cfg_data[6:0];
				else
					loc_count = cfg_data;
			end
			if (in_valid && !in_stall) begin
				predict_item(r);
				expected_q.push_back(r);
			end
			if (out_valid && !out_stall) begin
				if (expected_q.size() == 0) begin
					report("unexpected item", 64'(hit_count), 64'd0);
				end else begin
					e = expected_q.pop_front();
					if (hit_count !== e.hits)
						report("hit_count", 64'(hit_count), 64'(e.hits));
					if (read_word !== e.word)
						report("read_word", read_word, e.word);
					if (location_distance !== e.loc_dist)
						report("location_distance", 64'(location_distance),
							64'(e.loc_dist));
				end
			end
		end
		pending = expected_q.size();
	end

endmodule

[tb/tb_sparse_distributed_memory_engine_top.sv]
`timescale 1ns / 1ps

module tb_sparse_distributed_memory_engine_top;
	import sdme_pkg::*;

	localparam int LOCATIONS = 1024;
	localparam int DIMENSION = 64;
	// idle cycles allowed without any item accepted or returned: reset clear pass plus
	// the slowest read at full count, with plenty of margin for stalls
	localparam int STALL_LIMIT = 20000;
	localparam int RANDOM_ITEMS = 300;
	localparam int BLOCK_ITEMS = 50;
	// locations 0 .. LOADED_LOCS-1 and the last one get addresses; counts stay
	// within the loaded range so no scan touches an unloaded location
	localparam int LOADED_LOCS = 96;
	localparam int SAT_WRITES = 130;
	localparam logic [63:0] SAT_PATTERN = 64'hA5A5_A5A5_A5A5_A5A5;
	localparam logic [2:0] OPC_SPARE_LO = 3'd6;
	localparam logic [2:0] OPC_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  opcode = '0;
	logic [9:0]  location_index = '0;
	logic [63:0] address = '0;
	logic [63:0] second_address = '0;
	logic [63:0] data_word = '0;
	logic [6:0]  query_radius = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] hit_count;
	logic [63:0] read_word;
	logic [6:0]  location_distance;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [10:0] cfg_data = '0;

	int errors;
	int pending;
	int send_idle_pct = 13;
	int recv_idle_pct = 67;
	int quiet_cycles = 0;
	logic [63:0] centers [4];

	always #5 clk = ~clk;

	sparse_distributed_memory_engine_top #(
		.LOCATIONS(LOCATIONS),
		.DIMENSION(DIMENSION)
	) dut (.*);

	sdme_scoreboard #(
		.LOCATIONS(LOCATIONS),
		.DIMENSION(DIMENSION)
	) u_scoreboard (.*);

	// receiver backpressure, redrawn every falling edge
	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// watchdog: the run must keep moving items in or out
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_sparse_distributed_memory_engine_top: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// a location that holds an address
	function automatic logic [9:0] loaded_idx();
		return ($urandom_range(7) == 0) ? 10'(LOCATIONS - 1) :
			10'($urandom_range(LOADED_LOCS - 1));
	endfunction

	// address near one of the cluster centers so activations actually happen
	function automatic logic [63:0] near_addr(int max_flips);
		logic [63:0] a;
		int flips;
		a = centers[$urandom_range(3)];
		flips = $urandom_range(max_flips);
		repeat (flips)
			a[$urandom_range(63)] ^= 1'b1;
		return a;
	endfunction

	// present one item; valid stays high until it is taken
	task automatic send_item(logic [2:0] op, logic [9:0] idx, logic [63:0] a,
			logic [63:0] a2, logic [63:0] d, logic [6:0] qr);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		opcode = op;
		location_index = idx;
		address = a;
		second_address = a2;
		data_word = d;
		query_radius = qr;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
		in_valid = 1'b0;
	endtask

	// let every outstanding item come back before touching registers
	task automatic drain();
		while (pending != 0)
			@(negedge clk);
		repeat (20)
			@(negedge clk);
	endtask

	task automatic write_cfg(logic idx, logic [10:0] value);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_config(logic [6:0] radius, logic [10:0] count);
		drain();
		write_cfg(CFG_RADIUS, {4'd0, radius});
		write_cfg(CFG_COUNT, count);
	endtask

	task automatic random_item();
		int pick;
		logic [6:0] qr;
		pick = $urandom_range(99);
		qr = ($urandom_range(3) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(8, 30));
		if (pick < 10)
			send_item(OPC_LOAD, 10'($urandom_range(LOCATIONS - 1)), near_addr(16), rand64(),
				rand64(), qr);
		else if (pick < 35)
			send_item(OPC_WRITE, 10'($urandom), near_addr(24), rand64(), rand64(), qr);
		else if (pick < 60)
			send_item(OPC_READ, 10'($urandom), near_addr(24), rand64(), rand64(), qr);
		else if (pick < 75)
			send_item(OPC_COUNT, 10'($urandom), near_addr(24), rand64(), rand64(), qr);
		else if (pick < 85)
			send_item(OPC_ISECT, 10'($urandom), near_addr(24), near_addr(24), rand64(), qr);
		else if (pick < 95)
			send_item(OPC_DIST, loaded_idx(), ($urandom_range(4) == 0) ? rand64() :
				near_addr(24), rand64(), rand64(), qr);
		else
			send_item($urandom_range(1) ? OPC_SPARE_LO : OPC_SPARE_HI, 10'($urandom),
				rand64(), rand64(), rand64(), 7'($urandom));
	endtask

	initial begin
		logic [6:0]  radius_tab [6];
		logic [10:0] count_tab [6];
		radius_tab = '{7'd24, 7'd0, 7'd64, 7'd16, 7'd127, 7'd28};
		count_tab = '{11'(LOADED_LOCS), 11'd1, 11'd0, 11'd37, 11'd64, 11'(LOADED_LOCS)};
		foreach (centers[k])
			centers[k] = rand64();

		repeat (9)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// scans cover only the loaded locations
		set_config(7'd24, 11'(LOADED_LOCS));

		// the two extreme addresses land at the ends of the table
		for (int i = 0; i < LOADED_LOCS; i++) begin
			if (i == 0)
				send_item(OPC_LOAD, 10'(i), '0, rand64(), rand64(), '0);
			else
				send_item(OPC_LOAD, 10'(i), near_addr(12), rand64(), rand64(), '0);
		end
		send_item(OPC_LOAD, 10'(LOCATIONS - 1), '1, rand64(), rand64(), '1);

		// directed: each op, field extremes, ties on an empty read
		send_item(OPC_READ, '0, centers[0], '0, '0, '0);
		send_item(OPC_WRITE, '0, centers[0], '0, '1, '0);
		send_item(OPC_WRITE, '1, centers[1], '1, '0, '1);
		send_item(OPC_READ, '0, centers[0], '0, '0, '0);
		send_item(OPC_READ, '0, centers[1], '0, '0, '0);
		send_item(OPC_READ, '0, '1, '0, '0, '0);
		send_item(OPC_COUNT, '0, centers[2], '0, '0, 7'd0);
		send_item(OPC_COUNT, '0, centers[2], '0, '0, 7'd64);
		send_item(OPC_COUNT, '0, '0, '0, '0, 7'd127);
		send_item(OPC_ISECT, '0, centers[0], centers[1], '0, 7'd30);
		send_item(OPC_ISECT, '0, '0, '1, '1, 7'd64);
		send_item(OPC_DIST, '0, '1, '0, '0, '0);
		send_item(OPC_DIST, '1, '0, '1, '1, '1);
		send_item(OPC_SPARE_LO, '1, '1, '1, '1, '1);
		send_item(OPC_SPARE_HI, '0, centers[3], '0, '1, '0);

		// saturation: two locations share one address at exact-match radius, so
		// every write hits both; columns set in the pattern run up, the rest down, into the clamps
		set_config(7'd0, 11'd2);
		send_item(OPC_LOAD, 10'd0, centers[0], '0, '0, '0);
		send_item(OPC_LOAD, 10'd1, centers[0], '0, '0, '0);
		for (int i = 0; i < SAT_WRITES; i++)
			send_item(OPC_WRITE, '0, centers[0], '0, SAT_PATTERN, '0);
		send_item(OPC_READ, '0, centers[0], '0, '0, '0);
		send_item(OPC_READ, '0, ~centers[0], '0, '0, '0);
		send_item(OPC_WRITE, '0, centers[0], '0, ~SAT_PATTERN, '0);
		send_item(OPC_READ, '0, centers[0], '0, '0, '0);

		// random part, three backpressure regimes, registers changed every block
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % BLOCK_ITEMS == 0) begin
				drain();
				if (i == RANDOM_ITEMS / 3) begin
					send_idle_pct = 67;
					recv_idle_pct = 13;
				end else if (i == 2 * (RANDOM_ITEMS / 3)) begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
				set_config(radius_tab[i / BLOCK_ITEMS], count_tab[i / BLOCK_ITEMS]);
			end
			random_item();
		end

		drain();
		repeat (100)
			@(negedge clk);
		if (errors == 0)
			$display("tb_sparse_distributed_memory_engine_top: PASS");
		else
			$display("tb_sparse_distributed_memory_engine_top: FAIL");
		$finish;
	end

endmodule

[sim.f]
rtl/core/sdme_pkg.sv
rtl/core/sdme_front.sv
rtl/core/sdme_back.sv
rtl/core/sparse_distributed_memory_engine_top.sv
rtl/core/sdme_checker.sv
tb/sdme_scoreboard.sv
tb/tb_sparse_distributed_memory_engine_top.sv
